@@ sv/drup_pkg.sv @@
// Package for the delimited record UTF-8 parser.
// Holds beat types, parser state, codes and limits shared by the step logic and top level.
// No dependencies.
package drup_pkg;

  // Most results that one input beat can cause.
  localparam int MaxResults = 5;

  localparam logic [7:0]  RecSep    = 8'h1E;
  localparam logic [7:0]  FldSep    = 8'h1F;
  // U+FFFD encoded, first byte lowest
  localparam logic [31:0] ReplBytes = 32'h00BD_BFEF;

  // Reset values of the configuration registers
  localparam logic [22:0] MaxBlobBytesRst = 23'd3145728;
  localparam logic [15:0] MaxEntriesRst   = 16'd20000;
  localparam logic [11:0] MaxFieldLenRst  = 12'd1024;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_BLOB_BYTES = 2'd0;
  localparam logic [1:0] CFG_MAX_ENTRIES    = 2'd1;
  localparam logic [1:0] CFG_MAX_FIELD_LEN  = 2'd2;

  // Input commands
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_TEXT      = 2'd0;
  localparam logic [1:0] KIND_ENTRY_END = 2'd1;
  localparam logic [1:0] KIND_BLOB_END  = 2'd2;

  // Range rule for the second byte of a multi-byte sequence
  localparam logic [2:0] SBC_ANY  = 3'd0; // 80..BF
  localparam logic [2:0] SBC_E0   = 3'd1; // A0..BF
  localparam logic [2:0] SBC_ED   = 3'd2; // 80..9F
  localparam logic [2:0] SBC_F0   = 3'd3; // 90..BF
  localparam logic [2:0] SBC_F4   = 3'd4; // 80..8F

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  field_index;
    logic [2:0]  byte_count;
    logic [31:0] text_bytes;
    logic [15:0] entry_count;
    logic        oversized;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic [23:0] pending_seq;
    logic [1:0]  pending_count;
    logic [1:0]  needed_continuations;
    logic [2:0]  second_byte_class;
    logic [1:0]  field_number;
    logic [11:0] field_length;
    logic        field_truncated;
    logic        record_kept;
    logic        record_tail_skip;
    logic [15:0] entries_kept;
    logic [22:0] blob_bytes_seen;
    logic        entries_full;
  } parse_state_t;

  typedef struct packed {
    logic [22:0] max_blob_bytes;
    logic [15:0] max_entries;
    logic [11:0] max_field_len;
  } cfg_regs_t;

endpackage

@@ sv/drup_step.sv @@
// Combinational step of the delimited record UTF-8 parser.
// Takes the parser state and one input beat, gives the next state and up to five results.
// Depends on drup_pkg.
module drup_step import drup_pkg::*; (
  input  parse_state_t                   st,
  input  in_beat_t                       beat,
  input  cfg_regs_t                      cfg,
  output parse_state_t                   st_next,
  output out_beat_t [MaxResults-1:0]     res,
  output logic [2:0]                     res_n
);

  typedef struct packed {
    parse_state_t                  s;
    out_beat_t [MaxResults-1:0]    r;
    logic [2:0]                    n;
  } work_t;

  function automatic work_t push(work_t w, out_beat_t b);
    if (w.n < 3'(MaxResults)) begin
      w.r[w.n] = b;
      w.n      = w.n + 3'd1;
    end
    return w;
  endfunction

  function automatic out_beat_t mk(logic [1:0] kind, logic [1:0] fidx, logic [2:0] cnt,
                                   logic [31:0] bytes, logic [15:0] ecount, logic over);
    out_beat_t b;
    b.kind        = kind;
    b.field_index = fidx;
    b.byte_count  = cnt;
    b.text_bytes  = bytes;
    b.entry_count = ecount;
    b.oversized   = over;
    b.last        = 1'b0;
    return b;
  endfunction

  // Truncation stops the field at the first code point that does not fit.
  function automatic work_t emit_text(work_t w, logic [31:0] bytes, logic [2:0] n,
                                      logic [11:0] max_len);
    logic [12:0] sum;
    sum = {1'b0, w.s.field_length} + 13'(n);
    if (!w.s.field_truncated) begin
      if (sum > {1'b0, max_len}) begin
        w.s.field_truncated = 1'b1;
      end else begin
        w.s.field_length = sum[11:0];
        if (w.s.field_number == 2'd0) begin
          w.s.record_kept = 1'b1;
        end
        w = push(w, mk(KIND_TEXT, w.s.field_number, n, bytes, 16'd0, 1'b0));
      end
    end
    return w;
  endfunction

  function automatic work_t clear_pending(work_t w);
    w.s.pending_seq          = '0;
    w.s.pending_count        = '0;
    w.s.needed_continuations = '0;
    w.s.second_byte_class    = SBC_ANY;
    return w;
  endfunction

  // Every pending byte of a broken sequence becomes one U+FFFD.
  function automatic work_t flush_pending(work_t w, logic [11:0] max_len);
    logic [1:0] cnt;
    cnt = w.s.pending_count;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < cnt) begin
        w = emit_text(w, ReplBytes, 3'd3, max_len);
      end
    end
    return clear_pending(w);
  endfunction

  function automatic logic cont_ok(parse_state_t s, logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (s.pending_count == 2'd1) begin
      case (s.second_byte_class)
        SBC_E0:  lo = 8'hA0;
        SBC_ED:  hi = 8'h9F;
        SBC_F0:  lo = 8'h90;
        SBC_F4:  hi = 8'h8F;
        default: ;
      endcase
    end
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic work_t start_seq(work_t w, logic [7:0] b, logic [1:0] need,
                                      logic [2:0] cls);
    w.s.pending_seq          = {16'd0, b};
    w.s.pending_count        = 2'd1;
    w.s.needed_continuations = need;
    w.s.second_byte_class    = cls;
    return w;
  endfunction

  function automatic work_t decode_byte(work_t w, logic [7:0] b, logic [11:0] max_len);
    logic [31:0] seq;
    logic [2:0]  n;
    logic        done;
    done = 1'b0;
    seq  = {8'd0, w.s.pending_seq} | ({24'd0, b} << {w.s.pending_count, 3'b000});
    n    = {1'b0, w.s.pending_count} + 3'd1;
    if (w.s.needed_continuations != 2'd0) begin
      if (cont_ok(w.s, b)) begin
        done = 1'b1;
        if (w.s.needed_continuations == 2'd1) begin
          w = clear_pending(w);
          w = emit_text(w, seq, n, max_len);
        end else begin
          w.s.pending_seq          = seq[23:0];
          w.s.pending_count        = w.s.pending_count + 2'd1;
          w.s.needed_continuations = w.s.needed_continuations - 2'd1;
        end
      end else begin
        w = flush_pending(w, max_len);
      end
    end
    if (!done) begin
      if (b < 8'h80)                     w = emit_text(w, {24'd0, b}, 3'd1, max_len);
      else if (b >= 8'hC2 && b <= 8'hDF) w = start_seq(w, b, 2'd1, SBC_ANY);
      else if (b == 8'hE0)               w = start_seq(w, b, 2'd2, SBC_E0);
      else if (b == 8'hED)               w = start_seq(w, b, 2'd2, SBC_ED);
      else if (b >= 8'hE1 && b <= 8'hEF) w = start_seq(w, b, 2'd2, SBC_ANY);
      else if (b == 8'hF0)               w = start_seq(w, b, 2'd3, SBC_F0);
      else if (b >= 8'hF1 && b <= 8'hF3) w = start_seq(w, b, 2'd3, SBC_ANY);
      else if (b == 8'hF4)               w = start_seq(w, b, 2'd3, SBC_F4);
      else                               w = emit_text(w, ReplBytes, 3'd3, max_len);
    end
    return w;
  endfunction

  function automatic work_t clear_record(work_t w);
    w = clear_pending(w);
    w.s.field_number     = '0;
    w.s.field_length     = '0;
    w.s.field_truncated  = 1'b0;
    w.s.record_kept      = 1'b0;
    w.s.record_tail_skip = 1'b0;
    return w;
  endfunction

  function automatic work_t close_record(work_t w, cfg_regs_t c);
    w = flush_pending(w, c.max_field_len);
    if (w.s.record_kept) begin
      w = push(w, mk(KIND_ENTRY_END, 2'd0, 3'd0, 32'd0, 16'd0, 1'b0));
      w.s.entries_kept = w.s.entries_kept + 16'd1;
      if (w.s.entries_kept >= c.max_entries) begin
        w.s.entries_full = 1'b1;
      end
    end
    return clear_record(w);
  endfunction

  work_t w;
  logic  full;

  always_comb begin
    w.s  = st;
    w.r  = '0;
    w.n  = '0;
    full = st.entries_full || (st.entries_kept >= cfg.max_entries);
    if (beat.cmd == CMD_DATA) begin
      if (w.s.blob_bytes_seen != '1) begin
        w.s.blob_bytes_seen = w.s.blob_bytes_seen + 23'd1;
      end
      if (full) begin
        w.s.entries_full = 1'b1;
      end else if (beat.data_byte == RecSep) begin
        w = close_record(w, cfg);
      end else if (w.s.record_tail_skip) begin
        // rest of record ignored
      end else if (beat.data_byte == FldSep) begin
        w = flush_pending(w, cfg.max_field_len);
        if ((w.s.field_number == 2'd0 && !w.s.record_kept) || w.s.field_number == 2'd3) begin
          w.s.record_tail_skip = 1'b1;
        end else begin
          w.s.field_number    = w.s.field_number + 2'd1;
          w.s.field_length    = '0;
          w.s.field_truncated = 1'b0;
        end
      end else begin
        w = decode_byte(w, beat.data_byte, cfg.max_field_len);
      end
    end else begin
      if (!full) begin
        w = close_record(w, cfg);
      end
      w = push(w, mk(KIND_BLOB_END, 2'd0, 3'd0, 32'd0, w.s.entries_kept,
                     w.s.blob_bytes_seen > cfg.max_blob_bytes));
      w = clear_record(w);
      w.s.entries_kept    = '0;
      w.s.blob_bytes_seen = '0;
      w.s.entries_full    = 1'b0;
    end
    if (w.n != 3'd0) begin
      w.r[w.n - 3'd1].last = 1'b1;
    end
  end

  assign st_next = w.s;
  assign res     = w.r;
  assign res_n   = w.n;

endmodule

@@ sv/delimited_record_utf8_parser_unit.sv @@
// The first result of an accepted beat is on out_beat in the next cycle.
// Throughput: one input beat per cycle while each beat yields at most one result and
//   out_stall is low; a beat with k results (k up to 5) stalls the input until its last
//   result is leaving, set by the single-entry-per-cycle drain of the result buffer.
// Reset (rst, synchronous, active high): parser state and buffer cleared,
//   configuration registers return to 3145728 / 20000 / 1024.
module delimited_record_utf8_parser_unit import drup_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_beat,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_beat,
  // configuration writes
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [22:0] cfg_data
);

  // Configuration registers; the user must write them only while the parser is idle, the block does not enforce it.
  cfg_regs_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_blob_bytes <= MaxBlobBytesRst;
      cfg.max_entries    <= MaxEntriesRst;
      cfg.max_field_len  <= MaxFieldLenRst;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_BLOB_BYTES: cfg.max_blob_bytes <= cfg_data;
        CFG_MAX_ENTRIES:    cfg.max_entries    <= cfg_data[15:0];
        CFG_MAX_FIELD_LEN:  cfg.max_field_len  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Parser state: the partial UTF-8 sequence, field/record bookkeeping, counters.
  parse_state_t st;
  parse_state_t st_next;

  // Results of the accepted beat, computed in one pass by the step logic.
  out_beat_t [MaxResults-1:0] step_res;
  logic [2:0]                 step_n;

  drup_step u_step (
    .st      (st),
    .beat    (in_beat),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (step_res),
    .res_n   (step_n)
  );

  // Result buffer: a short shift line, head at entry 0, rbuf_n beats left.
  out_beat_t [MaxResults-1:0] rbuf;
  logic [2:0]                 rbuf_n;

  logic in_acc;
  logic out_pop;

  assign out_valid = (rbuf_n != 3'd0);
  assign out_beat  = rbuf[0];
  assign out_pop   = out_valid && !out_stall;

  // Accept a new beat when the buffer is empty, or its only beat leaves this cycle.
  assign in_stall = (rbuf_n > 3'd1) || (rbuf_n == 3'd1 && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= '0;
      rbuf_n <= '0;
    end else if (in_acc) begin
      st     <= st_next;
      rbuf_n <= step_n;
    end else if (out_pop) begin
      rbuf_n <= rbuf_n - 3'd1;
    end
  end

  // Payload side needs no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rbuf <= step_res;
    end else if (out_pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        rbuf[i] <= rbuf[i + 1];
      end
    end
  end

`ifndef ASSERT_OFF
  // The head beat carries last exactly when it is the final buffered beat.
  a_last_at_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_beat.last == (rbuf_n == 3'd1)))
    else $error("last flag out of step with result buffer");

  // The buffer never holds more than one beat's worth of results.
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    rbuf_n <= 3'(MaxResults))
    else $error("result buffer overfilled");

  // A pending continuation always has a lead byte behind it.
  a_pending_lead: assert property (@(posedge clk) disable iff (rst)
    (st.needed_continuations != 2'd0) |-> (st.pending_count != 2'd0))
    else $error("continuation expected with no pending bytes");

  // Blob end returns the counters to zero.
  a_blob_end_clear: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_beat.cmd == CMD_END) |=>
      (st.entries_kept == 16'd0 && st.blob_bytes_seen == 23'd0 && !st.entries_full))
    else $error("blob end left counters set");

  // A blob-end result is always the final beat of its input.
  a_blob_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_beat.kind == KIND_BLOB_END) |-> out_beat.last)
    else $error("blob end result not marked last");
`endif

endmodule

@@ test/delimited_record_utf8_parser_unit_tb.sv @@
// Testbench for delimited_record_utf8_parser_unit: directed and random byte blobs, with each
// result beat checked against an in-bench parser model under changing idle and stall mixes.
// Depends on drup_pkg and the unit RTL.
module delimited_record_utf8_parser_unit_tb;
  import drup_pkg::*;

  // Cycles with no beat moving on either channel before the run is called hung.
  localparam int QuietLimit = 2000;
  // Settle time after the last expected result, before a register write or the verdict.
  localparam int SettleCycles = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_MAX_BLOB_BYTES;
  logic [22:0] cfg_data = '0;

  delimited_record_utf8_parser_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  in_beat_t    stim_q[$];        // beats waiting for the driver
  out_beat_t   expected_q[$];    // predicted result beats, oldest first
  int unsigned idle_pct = 0;     // chance per cycle that the sender holds off
  int unsigned stall_pct = 0;    // chance per cycle that the receiver stalls
  logic        in_taken = 1'b0;  // input beat accepted at the last rising edge
  int          quiet = 0;
  int          queued = 0;
  int          fail_count = 0;
  int          beats_in = 0;
  int          results_seen = 0;
  int          text_seen = 0;
  int          entry_ends_seen = 0;
  int          blob_ends_seen = 0;
  int          oversized_seen = 0;

  // Parser model: limits as last written, plus the parse state of the open blob.
  logic [22:0] lim_blob;
  logic [15:0] lim_entries;
  logic [11:0] lim_field;
  logic [23:0] seq_bytes;        // bytes of a partial UTF-8 sequence, first lowest
  logic [1:0]  seq_len;
  logic [1:0]  seq_need;         // continuation bytes still missing
  logic [2:0]  seq_rule;         // range rule for the second byte
  logic [1:0]  fld_num;
  logic [11:0] fld_len;
  logic        fld_cut;          // field hit its byte limit; rest of it is dropped
  logic        rec_kept;         // name produced text, record gets an entry end
  logic        rec_skip;         // skipping to the next record separator
  logic        ent_full;
  logic [15:0] ent_kept;
  logic [22:0] blob_seen;        // saturates
  int          beat_n;           // results predicted for the current input beat

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function void add_result(logic [1:0] k, logic [1:0] fi, logic [2:0] n, logic [31:0] txt,
                           logic [15:0] cnt, logic ovr);
    out_beat_t r;
    if (beat_n >= MaxResults) return;
    r.kind        = k;
    r.field_index = fi;
    r.byte_count  = n;
    r.text_bytes  = txt;
    r.entry_count = cnt;
    r.oversized   = ovr;
    r.last        = 1'b0;
    expected_q.insert(expected_q.size(), r);
    beat_n++;
  endfunction

  // One code point into the open field, unless the field is already cut.
  // The first code point that does not fit cuts the field for good.
  function void keep_text(logic [31:0] txt, int n);
    if (fld_cut) return;
    if (int'(fld_len) + n > int'(lim_field)) begin
      fld_cut = 1'b1;
      return;
    end
    fld_len = fld_len + 12'(n);
    if (fld_num == 2'd0) rec_kept = 1'b1;
    add_result(KIND_TEXT, fld_num, 3'(n), txt, 16'd0, 1'b0);
  endfunction

  function void drop_partial();
    seq_bytes = '0;
    seq_len   = '0;
    seq_need  = '0;
    seq_rule  = SBC_ANY;
  endfunction

  // Every byte of a broken sequence becomes one U+FFFD.
  function void flush_partial();
    int i;
    for (i = 0; i < int'(seq_len); i++) keep_text(ReplBytes, 3);
    drop_partial();
  endfunction

  function void open_seq(logic [7:0] b, logic [1:0] need, logic [2:0] rule);
    seq_bytes = {16'd0, b};
    seq_len   = 2'd1;
    seq_need  = need;
    seq_rule  = rule;
  endfunction

  function void clear_entry();
    drop_partial();
    fld_num  = '0;
    fld_len  = '0;
    fld_cut  = 1'b0;
    rec_kept = 1'b0;
    rec_skip = 1'b0;
  endfunction

  function void close_entry();
    flush_partial();
    if (rec_kept) begin
      add_result(KIND_ENTRY_END, 2'd0, 3'd0, 32'd0, 16'd0, 1'b0);
      ent_kept = ent_kept + 16'd1;
      if (ent_kept >= lim_entries) ent_full = 1'b1;
    end
    clear_entry();
  endfunction

  function void decode_utf8(logic [7:0] b);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [31:0] whole;
    int          n;
    if (seq_need != 2'd0) begin
      lo = 8'h80;
      hi = 8'hBF;
      if (seq_len == 2'd1) begin
        case (seq_rule)
          SBC_E0:  lo = 8'hA0;
          SBC_ED:  hi = 8'h9F;
          SBC_F0:  lo = 8'h90;
          SBC_F4:  hi = 8'h8F;
          default: lo = 8'h80;
        endcase
      end
      if (b >= lo && b <= hi) begin
        whole = {8'd0, seq_bytes} | ({24'd0, b} << (8 * seq_len));
        if (seq_need == 2'd1) begin
          n = int'(seq_len) + 1;
          drop_partial();
          keep_text(whole, n);
        end else begin
          seq_bytes = whole[23:0];
          seq_len   = seq_len + 2'd1;
          seq_need  = seq_need - 2'd1;
        end
        return;
      end
      // cannot continue: flush, then take this byte afresh
      flush_partial();
    end
    if (b < 8'h80)                     keep_text({24'd0, b}, 1);
    else if (b >= 8'hC2 && b <= 8'hDF) open_seq(b, 2'd1, SBC_ANY);
    else if (b == 8'hE0)               open_seq(b, 2'd2, SBC_E0);
    else if (b == 8'hED)               open_seq(b, 2'd2, SBC_ED);
    else if (b >= 8'hE1 && b <= 8'hEF) open_seq(b, 2'd2, SBC_ANY);
    else if (b == 8'hF0)               open_seq(b, 2'd3, SBC_F0);
    else if (b >= 8'hF1 && b <= 8'hF3) open_seq(b, 2'd3, SBC_ANY);
    else if (b == 8'hF4)               open_seq(b, 2'd3, SBC_F4);
    else                               keep_text(ReplBytes, 3);
  endfunction

  // Work out every result beat that one accepted input beat causes.
  function void predict_beat(in_beat_t ib);
    logic full;
    beat_n = 0;
    full = ent_full || (ent_kept >= lim_entries);
    if (ib.cmd == CMD_DATA) begin
      if (blob_seen != '1) blob_seen = blob_seen + 23'd1;
      if (full) begin
        ent_full = 1'b1;
      end else if (ib.data_byte == RecSep) begin
        close_entry();
      end else if (rec_skip) begin
        // extra field or dropped record: ignored up to the record separator
      end else if (ib.data_byte == FldSep) begin
        flush_partial();
        if ((fld_num == 2'd0 && !rec_kept) || fld_num >= 2'd3) begin
          rec_skip = 1'b1;
        end else begin
          fld_num = fld_num + 2'd1;
          fld_len = '0;
          fld_cut = 1'b0;
        end
      end else begin
        decode_utf8(ib.data_byte);
      end
    end else begin
      if (!full) close_entry();
      add_result(KIND_BLOB_END, 2'd0, 3'd0, 32'd0, ent_kept, blob_seen > lim_blob);
      clear_entry();
      ent_kept  = '0;
      blob_seen = '0;
      ent_full  = 1'b0;
    end
    if (beat_n > 0) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_failure(string msg);
    if (fail_count < 50) $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      note_failure($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             results_seen, name, got, want));
  endtask

  // Monitor: checks result beats, feeds accepted input beats to the model and
  // runs the watchdog. Everything is sampled at the rising edge.
  always @(posedge clk) begin : watch
    out_beat_t want;
    if (rst) begin
      lim_blob    = MaxBlobBytesRst;
      lim_entries = MaxEntriesRst;
      lim_field   = MaxFieldLenRst;
      clear_entry();
      ent_kept    = '0;
      blob_seen   = '0;
      ent_full    = 1'b0;
      expected_q.delete();
      in_taken <= 1'b0;
      quiet    <= 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      // check before predicting: a result seen now belongs to an older beat
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          note_failure($sformatf("result %0d (kind %0d) with nothing expected",
                                 results_seen, out_beat.kind));
        end else begin
          want = expected_q.pop_front();
          check_field("kind",        32'(out_beat.kind),        32'(want.kind));
          check_field("field_index", 32'(out_beat.field_index), 32'(want.field_index));
          check_field("byte_count",  32'(out_beat.byte_count),  32'(want.byte_count));
          check_field("text_bytes",  out_beat.text_bytes,       want.text_bytes);
          check_field("entry_count", 32'(out_beat.entry_count), 32'(want.entry_count));
          check_field("oversized",   32'(out_beat.oversized),   32'(want.oversized));
          check_field("last",        32'(out_beat.last),        32'(want.last));
          case (want.kind)
            KIND_TEXT:      text_seen++;
            KIND_ENTRY_END: entry_ends_seen++;
            default: begin
              blob_ends_seen++;
              if (want.oversized) oversized_seen++;
            end
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        beats_in++;
        predict_beat(in_beat);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("Timeout: no beat moved for %0d cycles, %0d results still expected",
                 QuietLimit, expected_q.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: inputs change at the falling edge. A presented beat is held until
  // the monitor saw it accepted; idle and stall draws follow the phase mix.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : feed
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (!in_valid || in_taken) begin
        if (stim_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_beat  <= stim_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function void put(logic [7:0] b);
    in_beat_t ib;
    ib.cmd       = CMD_DATA;
    ib.data_byte = b;
    stim_q.insert(stim_q.size(), ib);
    queued++;
  endfunction

  // data_byte is don't-care on an end beat, so it gets random bits
  function void put_end();
    in_beat_t ib;
    ib.cmd       = CMD_END;
    ib.data_byte = 8'($urandom_range(0, 255));
    stim_q.insert(stim_q.size(), ib);
    queued++;
  endfunction

  function logic [7:0] any_cont();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // One character: mostly well-formed UTF-8 with the tight second-byte ranges,
  // sometimes malformed sequences or plain noise (which may hit a separator).
  function void put_char();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        b = 8'($urandom_range(0, 127));
        put((b == RecSep || b == FldSep) ? 8'h61 : b);
      end
      4: begin
        put(8'($urandom_range(8'hC2, 8'hDF)));
        put(any_cont());
      end
      5: begin
        case ($urandom_range(0, 2))
          0: begin
            put(8'hE0);
            put(8'($urandom_range(8'hA0, 8'hBF)));
          end
          1: begin
            put(8'hED);
            put(8'($urandom_range(8'h80, 8'h9F)));
          end
          default: begin
            put(8'($urandom_range(8'hE1, 8'hEF)));
            put(any_cont());
          end
        endcase
        put(any_cont());
      end
      6: begin
        case ($urandom_range(0, 2))
          0: begin
            put(8'hF0);
            put(8'($urandom_range(8'h90, 8'hBF)));
          end
          1: begin
            put(8'hF4);
            put(8'($urandom_range(8'h80, 8'h8F)));
          end
          default: begin
            put(8'($urandom_range(8'hF1, 8'hF3)));
            put(any_cont());
          end
        endcase
        put(any_cont());
        put(any_cont());
      end
      7: begin
        case ($urandom_range(0, 3))
          0: put(any_cont());                                  // stray continuation
          1: put($urandom_range(0, 1) ? 8'($urandom_range(8'hF5, 8'hFF))
                                      : 8'($urandom_range(8'hC0, 8'hC1)));
          2: begin                                             // overlong E0
            put(8'hE0);
            put(8'($urandom_range(8'h80, 8'h9F)));
          end
          default: begin                                       // 4-byte lead cut short
            put(8'($urandom_range(8'hF0, 8'hF4)));
            put(any_cont());
          end
        endcase
      end
      default: put(8'($urandom_range(0, 255)));
    endcase
  endfunction

  // A record of one to six fields; names are rarely empty.
  function void put_record(bit closed);
    int nf;
    int nc;
    int f;
    int c;
    nf = $urandom_range(1, 6);
    for (f = 0; f < nf; f++) begin
      nc = $urandom_range(0, 3);
      if (f == 0 && nc == 0 && $urandom_range(0, 3) != 0) nc = 1;
      for (c = 0; c < nc; c++) put_char();
      if (f < nf - 1) put(FldSep);
    end
    if (closed) put(RecSep);
  endfunction

  function void fill_random(int target);
    int start;
    int nrec;
    int r;
    start = queued;
    while (queued - start < target) begin
      nrec = $urandom_range(1, 3);
      // the last record sometimes runs into the blob end unclosed
      for (r = 0; r < nrec; r++) put_record(r < nrec - 1 || $urandom_range(0, 3) != 0);
      put_end();
    end
  endfunction

  // Sender pause: all beats taken, every expected result in, then settle.
  task automatic wait_drained();
    while (stim_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [22:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_MAX_BLOB_BYTES: lim_blob    = val;
      CFG_MAX_ENTRIES:    lim_entries = val[15:0];
      default:            lim_field   = val[11:0];
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_limits(int blob_max, int entry_max, int field_max);
    write_reg(CFG_MAX_BLOB_BYTES, 23'(blob_max));
    write_reg(CFG_MAX_ENTRIES,    23'(entry_max));
    write_reg(CFG_MAX_FIELD_LEN,  23'(field_max));
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed blob at reset limits, no idling.
    put_end();                                                  // empty blob
    put(8'h00); put(8'hC2); put(8'h80); put(8'hFF);             // NUL, U+0080, bad byte
    put(FldSep);
    put(8'hE0); put(8'hA0); put(8'h80); put(8'hE0); put(8'h9F); // U+0800, overlong E0
    put(FldSep);
    put(8'hF4); put(8'h8F); put(8'hBF); put(8'hBF); put(8'hF0); // U+10FFFF, lead cut
    put(FldSep);                                                //   short by separator
    put(8'hED); put(8'hA0);                                     // surrogate attempt
    put(FldSep); put(RecSep);                                   // fifth field skipped
    put(FldSep); put(8'h42); put(RecSep);                       // empty name: dropped
    put(8'hE2); put_end();                                      // lead closed by blob end
    wait_drained();

    // Mid-range limits, still no idling.
    set_limits(60, 3, 6);
    fill_random(12);
    wait_drained();

    // Sender mostly idle; tight field limit, generous blob and entry limits.
    // Phase ends inside an open record after one kept entry.
    idle_pct = 81;
    set_limits(4194304, 65535, 4);
    fill_random(12);
    put(8'h41); put(RecSep); put(8'h42); put(FldSep); put(8'h43);
    wait_drained();

    // Receiver mostly stalling. Entry limit drops to the count of the open
    // blob, so its open record is left without an entry end; any blob of more
    // than one byte is oversized from here on.
    idle_pct  = 0;
    stall_pct = 81;
    set_limits(1, 1, 4095);
    fill_random(12);
    wait_drained();

    // Both sides idling now and then.
    idle_pct  = 22;
    stall_pct = 22;
    set_limits($urandom_range(20, 80), 2, $urandom_range(5, 16));
    fill_random(12);
    wait_drained();

    if (expected_q.size() != 0)
      note_failure($sformatf("%0d expected results never came", expected_q.size()));
    $display("Covered %0d input beats; checked %0d results: %0d code points, %0d entry ends,",
             beats_in, results_seen, text_seen, entry_ends_seen);
    $display("  %0d blob ends (%0d oversized) across five limit settings and four idle mixes",
             blob_ends_seen, oversized_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
